/* hw/rtl/ftgc_pkg.sv */
// Shared types and constants for the finder triple geometry check.
// No dependencies.
package ftgc_pkg;

    localparam int KsqW    = 34;
    localparam int CfgDataW = 24;
    localparam int CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] RegSquareTol = 2'd0;
    localparam logic [CfgIdxW-1:0] RegAreaTol   = 2'd1;
    localparam logic [CfgIdxW-1:0] RegAngleTol  = 2'd2;
    localparam logic [CfgIdxW-1:0] RegDiagCos   = 2'd3;

    localparam logic [15:0] SquareTolReset = 16'd80;
    localparam logic [23:0] AreaTolReset   = 24'd2500;
    localparam logic [15:0] AngleTolReset  = 16'd44892;
    localparam logic [15:0] DiagCosReset   = 16'd46341;

    typedef enum logic [1:0] {
        VERDICT_ACCEPTED   = 2'd0,
        VERDICT_NOT_SQUARE = 2'd1,
        VERDICT_AREA       = 2'd2,
        VERDICT_ANGLE      = 2'd3
    } verdict_t;

    // squared tolerances, derived from the config registers
    typedef struct packed {
        logic [KsqW-1:0] ksq_zero;   // t^2
        logic [KsqW-1:0] ksq_lo;     // (d - t)^2
        logic [KsqW-1:0] ksq_hi;     // (d + t)^2
        logic            zero_pos;   // t > 0
        logic            lo_free;    // d < t: lower diagonal bound always met
        logic            hi_pos;     // d + t > 0
    } cfg_terms_t;

    typedef struct packed {
        logic near_zero;
        logic near_diag;
    } angle_flags_t;

endpackage

/* hw/rtl/ftgc_if.sv */
// Valid/ready channel interfaces for the finder triple geometry check.
// Depends on nothing.
interface ftgc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] first_x;
    logic [15:0] first_y;
    logic [15:0] first_width;
    logic [15:0] first_height;
    logic [15:0] second_x;
    logic [15:0] second_y;
    logic [15:0] second_width;
    logic [15:0] second_height;
    logic [15:0] third_x;
    logic [15:0] third_y;
    logic [15:0] third_width;
    logic [15:0] third_height;

    modport source (output valid, first_x, first_y, first_width, first_height,
                    second_x, second_y, second_width, second_height,
                    third_x, third_y, third_width, third_height, input ready);
    modport sink   (input valid, first_x, first_y, first_width, first_height,
                    second_x, second_y, second_width, second_height,
                    third_x, third_y, third_width, third_height, output ready);
endinterface

interface ftgc_out_if;
    logic       valid;
    logic       ready;
    logic       matched;
    logic [1:0] verdict;

    modport source (output valid, matched, verdict, input ready);
    modport sink   (input valid, matched, verdict, output ready);
endinterface

/* hw/rtl/ftgc_angle.sv */
// Six-stage pipeline judging the cosine at one vertex against the tolerances.
// Depends on ftgc_pkg.
module ftgc_angle (
    input  logic                    clk,
    input  logic                    advance,
    input  logic [15:0]             ax,
    input  logic [15:0]             ay,
    input  logic [15:0]             bx,
    input  logic [15:0]             by,
    input  logic [15:0]             cx,
    input  logic [15:0]             cy,
    input  ftgc_pkg::cfg_terms_t    terms,
    output ftgc_pkg::angle_flags_t  flags
);
    // stage 1: edge vectors
    logic signed [16:0] x1_reg, y1_reg, x2_reg, y2_reg;
    // stage 2: products
    logic [33:0]        xx1_reg, yy1_reg, xx2_reg, yy2_reg;
    logic signed [33:0] px_reg, py_reg;
    // stage 3: norms and dot magnitude
    logic [33:0] n1_reg, n2_reg, dm_reg;
    logic        zero3_reg;
    // stage 4: dot^2 and norm product
    logic [67:0] d2_reg, nn_reg;
    logic        zero4_reg;
    // stage 5: partial products, low and high half of nn times each k^2
    logic [67:0] zl_reg, zh_reg, ll_reg, lh_reg, hl_reg, hh_reg;
    logic [67:0] d2b_reg;
    logic        zero5_reg;
    ftgc_pkg::angle_flags_t flags_reg;

    logic signed [34:0] dot;
    logic [101:0] lhs, rz, rl, rh;
    logic below_z, above_l, below_h;

    always_comb
    begin
        dot = 35'(px_reg) + 35'(py_reg);
        lhs = {2'b00, d2b_reg, 32'd0};
        rz  = 102'(zl_reg) + {zh_reg, 34'd0};
        rl  = 102'(ll_reg) + {lh_reg, 34'd0};
        rh  = 102'(hl_reg) + {hh_reg, 34'd0};
        below_z = zero5_reg ? terms.zero_pos : (lhs < rz);
        above_l = terms.lo_free || (!zero5_reg && (lhs > rl));
        below_h = zero5_reg ? terms.hi_pos : (lhs < rh);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x1_reg <= $signed({1'b0, bx}) - $signed({1'b0, ax});
            y1_reg <= $signed({1'b0, by}) - $signed({1'b0, ay});
            x2_reg <= $signed({1'b0, cx}) - $signed({1'b0, ax});
            y2_reg <= $signed({1'b0, cy}) - $signed({1'b0, ay});

            xx1_reg <= 34'(x1_reg * x1_reg);
            yy1_reg <= 34'(y1_reg * y1_reg);
            xx2_reg <= 34'(x2_reg * x2_reg);
            yy2_reg <= 34'(y2_reg * y2_reg);
            px_reg  <= x1_reg * x2_reg;
            py_reg  <= y1_reg * y2_reg;

            n1_reg    <= xx1_reg + yy1_reg;
            n2_reg    <= xx2_reg + yy2_reg;
            dm_reg    <= dot[34] ? 34'(-dot) : dot[33:0];
            zero3_reg <= ((xx1_reg + yy1_reg) == 34'd0) || ((xx2_reg + yy2_reg) == 34'd0);

            d2_reg    <= dm_reg * dm_reg;
            nn_reg    <= n1_reg * n2_reg;
            zero4_reg <= zero3_reg;

            zl_reg    <= nn_reg[33:0] * terms.ksq_zero;
            zh_reg    <= nn_reg[67:34] * terms.ksq_zero;
            ll_reg    <= nn_reg[33:0] * terms.ksq_lo;
            lh_reg    <= nn_reg[67:34] * terms.ksq_lo;
            hl_reg    <= nn_reg[33:0] * terms.ksq_hi;
            hh_reg    <= nn_reg[67:34] * terms.ksq_hi;
            d2b_reg   <= d2_reg;
            zero5_reg <= zero4_reg;

            flags_reg.near_zero <= below_z;
            flags_reg.near_diag <= above_l && below_h;
        end
    end

    assign flags = flags_reg;
endmodule

/* hw/rtl/finder_triple_geometry_check.sv */
// Top level of the finder triple geometry check: config registers, shape and
// area tests, three angle pipelines and the verdict. Depends on ftgc_pkg,
// ftgc_if and ftgc_angle.
//
// Usage:
//   in_item carries one candidate triple (three squares, Q12.4 centre, width
//   and height); out_result carries matched and a verdict code. Transfers are
//   valid/ready on both channels.
//   Depth: 7 register stages; the result is held in the output register.
//   Throughput: one triple per cycle while results are taken; the 34x34-bit
//   norm and tolerance products are the deepest stages of the angle
//   pipelines. The whole pipeline advances together whenever the output
//   register is empty or being taken, so a stalled receiver holds every
//   stage in place and drops ready; nothing is lost or repeated.
//   Config writes (cfg_we, cfg_index, cfg_data) are to go in only while
//   the block is idle; the block itself does not enforce this.
//   Reset clears all valid bits and loads the default tolerances.
module finder_triple_geometry_check (
    input  logic                           clk,
    input  logic                           rst_n,
    ftgc_in_if.sink                        in_item,
    ftgc_out_if.source                     out_result,
    input  logic                           cfg_we,
    input  logic [ftgc_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [ftgc_pkg::CfgDataW-1:0]  cfg_data
);
    localparam int Depth = 7;

    logic [15:0] square_tol_reg, angle_tol_reg, diag_cos_reg;
    logic [23:0] area_tol_reg;
    ftgc_pkg::cfg_terms_t terms_reg, terms_next;

    logic [Depth-1:0] valid_reg;
    logic advance;

    // stage 1: shape flags and areas
    logic        not_sq1_reg;
    logic [23:0] a1_reg, a2_reg, a3_reg;
    // stage 2 onward: delayed early verdict bits
    logic [Depth-2:1] not_sq_reg, area_far_reg;

    ftgc_pkg::angle_flags_t f1, f2, f3;
    ftgc_pkg::verdict_t verdict_reg, verdict_next;

    assign advance       = !valid_reg[Depth-1] || out_result.ready;
    assign in_item.ready = advance;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            square_tol_reg <= ftgc_pkg::SquareTolReset;
            area_tol_reg   <= ftgc_pkg::AreaTolReset;
            angle_tol_reg  <= ftgc_pkg::AngleTolReset;
            diag_cos_reg   <= ftgc_pkg::DiagCosReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ftgc_pkg::RegSquareTol: square_tol_reg <= cfg_data[15:0];
                ftgc_pkg::RegAreaTol:   area_tol_reg   <= cfg_data;
                ftgc_pkg::RegAngleTol:  angle_tol_reg  <= cfg_data[15:0];
                ftgc_pkg::RegDiagCos:   diag_cos_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // squared tolerances, registered behind the config registers
    always_comb
    begin
        logic [15:0] lo;
        logic [16:0] hi;
        lo = diag_cos_reg - angle_tol_reg;
        hi = 17'(diag_cos_reg) + 17'(angle_tol_reg);
        terms_next.ksq_zero = 34'(angle_tol_reg) * 34'(angle_tol_reg);
        terms_next.ksq_lo   = 34'(lo) * 34'(lo);
        terms_next.ksq_hi   = 34'(hi) * 34'(hi);
        terms_next.zero_pos = angle_tol_reg != 16'd0;
        terms_next.lo_free  = diag_cos_reg < angle_tol_reg;
        terms_next.hi_pos   = hi != 17'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            terms_reg <= '0;
        else
            terms_reg <= terms_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (advance)
            valid_reg <= {valid_reg[Depth-2:0], in_item.valid};
    end

    function automatic logic off_square(input logic [15:0] w, input logic [15:0] h,
                                        input logic [15:0] tol);
        logic [15:0] diff;
        diff = (h > w) ? h - w : w - h;
        return diff > tol;
    endfunction

    function automatic logic far_area(input logic [23:0] a, input logic [23:0] b,
                                      input logic [23:0] tol);
        logic [23:0] diff;
        diff = (a > b) ? a - b : b - a;
        return diff > tol;
    endfunction

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            not_sq1_reg <= off_square(in_item.first_width, in_item.first_height,
                                      square_tol_reg)
                        || off_square(in_item.second_width, in_item.second_height,
                                      square_tol_reg)
                        || off_square(in_item.third_width, in_item.third_height,
                                      square_tol_reg);
            a1_reg <= 24'((32'(in_item.first_width) * 32'(in_item.first_height)) >> 8);
            a2_reg <= 24'((32'(in_item.second_width) * 32'(in_item.second_height)) >> 8);
            a3_reg <= 24'((32'(in_item.third_width) * 32'(in_item.third_height)) >> 8);

            not_sq_reg[1]   <= not_sq1_reg;
            area_far_reg[1] <= far_area(a1_reg, a2_reg, area_tol_reg)
                            || far_area(a1_reg, a3_reg, area_tol_reg);
            for (int i = 2; i <= Depth-2; i++)
            begin
                not_sq_reg[i]   <= not_sq_reg[i-1];
                area_far_reg[i] <= area_far_reg[i-1];
            end
            verdict_reg <= verdict_next;
        end
    end

    ftgc_angle u_angle1 (
        .clk(clk), .advance(advance),
        .ax(in_item.first_x),  .ay(in_item.first_y),
        .bx(in_item.second_x), .by(in_item.second_y),
        .cx(in_item.third_x),  .cy(in_item.third_y),
        .terms(terms_reg), .flags(f1)
    );
    ftgc_angle u_angle2 (
        .clk(clk), .advance(advance),
        .ax(in_item.second_x), .ay(in_item.second_y),
        .bx(in_item.first_x),  .by(in_item.first_y),
        .cx(in_item.third_x),  .cy(in_item.third_y),
        .terms(terms_reg), .flags(f2)
    );
    ftgc_angle u_angle3 (
        .clk(clk), .advance(advance),
        .ax(in_item.third_x),  .ay(in_item.third_y),
        .bx(in_item.first_x),  .by(in_item.first_y),
        .cx(in_item.second_x), .cy(in_item.second_y),
        .terms(terms_reg), .flags(f3)
    );

    // shape beats area beats angles
    always_comb
    begin
        priority if (not_sq_reg[Depth-2])
            verdict_next = ftgc_pkg::VERDICT_NOT_SQUARE;
        else if (area_far_reg[Depth-2])
            verdict_next = ftgc_pkg::VERDICT_AREA;
        else if (f1.near_zero)
            verdict_next = f2.near_diag ? ftgc_pkg::VERDICT_ACCEPTED
                                        : ftgc_pkg::VERDICT_ANGLE;
        else if (f1.near_diag && (f2.near_diag || f3.near_zero))
            verdict_next = ftgc_pkg::VERDICT_ACCEPTED;
        else
            verdict_next = ftgc_pkg::VERDICT_ANGLE;
    end

    assign out_result.valid   = valid_reg[Depth-1];
    assign out_result.verdict = verdict_reg;
    assign out_result.matched = verdict_reg == ftgc_pkg::VERDICT_ACCEPTED;
endmodule
